### sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants
// Payload structs, round constants and initial hash values for SHA-256.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int COUNT_BITS  = 61;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = QPTR_BITS + 1;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       fin;
	} cmd_t;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

### sv/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front: input acceptance and command queue
// Drops idle items and queues byte/end commands for the core.
// ----------------------------------------------------------------------------
module sha_front import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	output logic     cmd_valid,
	input  logic     cmd_take,
	output cmd_t     cmd_data
);

	cmd_t                 fifo_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic                 push;
	logic                 pop;

	assign in_stall  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign push      = in_valid && !in_stall && (in_data.has_byte || in_data.end_of_message);
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd_data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{data: in_data.msg_byte, has_byte: in_data.has_byte,
				fin: in_data.end_of_message};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			cnt_q <= cnt_q + QCNT_BITS'(push) - QCNT_BITS'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == QCNT_BITS'(QUEUE_DEPTH) |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> !pop) else $error("queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_BITS'(QUEUE_DEPTH)) else $error("count out of range");
`endif

endmodule

### sv/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core: block buffer, padding, compression and digest output
// One round per cycle; message schedule in a 16-word window.
// ----------------------------------------------------------------------------
module sha_core import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_take,
	input  cmd_t      cmd_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PAD   = 7'b0000010,
		ST_LOAD  = 7'b0000100,
		ST_ROUND = 7'b0001000,
		ST_ADD   = 7'b0010000,
		ST_EMIT  = 7'b0100000,
		ST_NEXT  = 7'b1000000
	} state_t;

	state_t                  state_q;
	logic [31:0]             blk_q [16];
	logic [COUNT_BITS-1:0]   count_q;
	logic [31:0]             h_q [8];
	logic [31:0]             v_q [8];
	logic [31:0]             w_q [16];
	logic [5:0]              round_q;
	logic [3:0]              ld_q;
	logic                    fin_q;
	logic                    final_q;
	logic                    pad_done_q;
	logic [2:0]              emit_q;
	logic [5:0]              pos;
	logic [63:0]             bits;
	logic [31:0]             t1, t2, s0, s1, w_new, ld_word;
	logic [31:0]             pad_word [16];

	assign pos      = count_q[5:0];
	assign bits     = 64'(count_q) << 3;
	assign cmd_take = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign out_data  = '{digest_word: h_q[emit_q], word_index: emit_q,
		last_word: (emit_q == 3'd7)};

	always_comb begin
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + K_TAB[round_q] + w_q[0];
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		ld_word = blk_q[ld_q];
		for (int k = 0; k < 16; k++) begin
			for (int j = 0; j < 4; j++) begin
				if (pad_done_q) pad_word[k][8*(3-j) +: 8] = 8'd0;
				else if (6'(4*k + j) == pos) pad_word[k][8*(3-j) +: 8] = PAD_BYTE;
				else if (6'(4*k + j) > pos) pad_word[k][8*(3-j) +: 8] = 8'd0;
				else pad_word[k][8*(3-j) +: 8] = blk_q[k][8*(3-j) +: 8];
			end
		end
		if (pad_done_q || pos < 6'd56) begin
			pad_word[14] = bits[63:32];
			pad_word[15] = bits[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid && cmd_data.has_byte)
			blk_q[pos[5:2]][{~pos[1:0], 3'd0} +: 8] <= cmd_data.data;
		if (state_q == ST_PAD) begin
			for (int k = 0; k < 16; k++) blk_q[k] <= pad_word[k];
		end
		if (state_q == ST_LOAD) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= ld_word;
		end
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (state_q == ST_LOAD && ld_q == 4'd0) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
			round_q    <= '0;
			ld_q       <= '0;
			fin_q      <= 1'b0;
			final_q    <= 1'b0;
			pad_done_q <= 1'b0;
			emit_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						fin_q      <= cmd_data.fin;
						pad_done_q <= 1'b0;
						final_q    <= 1'b0;
						ld_q       <= '0;
						if (cmd_data.has_byte) begin
							count_q <= count_q + COUNT_BITS'(1);
							if (pos == 6'd63) state_q <= ST_LOAD;
							else if (cmd_data.fin) state_q <= ST_PAD;
						end else if (cmd_data.fin) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					ld_q    <= '0;
					state_q <= ST_LOAD;
					final_q <= pad_done_q || (pos < 6'd56);
					pad_done_q <= 1'b1;
				end
				ST_LOAD: begin
					ld_q <= ld_q + 4'd1;
					if (ld_q == 4'd15) begin
						round_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					emit_q <= '0;
					if (final_q) state_q <= ST_EMIT;
					else if (fin_q) state_q <= ST_PAD;
					else state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					if (!out_stall) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
					count_q <= '0;
					fin_q   <= 1'b0;
					final_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_emit_final: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> final_q) else $error("digest before final block");
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && round_q == 6'd63 |=> state_q == ST_ADD)
		else $error("round count slip");
`endif

endmodule

### sv/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher: streaming SHA-256 top level
// Bytes are taken while idle; a block-closing byte starts load, rounds and hash add.
// End of message: one or two padded blocks, eight digest transfers, one restart.
// Rate is set by the single shared round unit; a 4-entry queue decouples input.
// Reset loads the initial hash values and clears the byte count and queue.
// ----------------------------------------------------------------------------
module sha256_stream_hasher import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic cmd_valid;
	logic cmd_take;
	cmd_t cmd_data;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_data(cmd_data)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_data(cmd_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule
